>>> rtl/core/tsb_pkg.sv
// ----------------------------------------------------------------------------
// TDMA beacon builder package
// Shared constants, register codes, state type and control structs.
// ----------------------------------------------------------------------------
package tsb_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int SLOT_AW   = $clog2(MAX_SLOTS);
    localparam int HDR_LEN   = 9;

    localparam logic [7:0] FREE_ENTRY = 8'hFF;

    localparam logic [7:0] FRAME_HEAD [0:7] = '{
        8'h41, 8'h88, 8'h88, 8'hCD, 8'hAB, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [15:0] GUARD_RESET  = 16'd50;
    localparam logic [15:0] SLOT_RESET   = 16'd50;
    localparam logic [5:0]  COUNT_RESET  = 6'd9;

    localparam logic [2:0] CFG_PERIOD = 3'd0;
    localparam logic [2:0] CFG_GUARD  = 3'd1;
    localparam logic [2:0] CFG_SLOT   = 3'd2;
    localparam logic [2:0] CFG_COUNT  = 3'd3;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic start_frame;
        logic fetch;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic beacon_hit;
        logic out_free;
        logic last_idx;
    } status_t;

endpackage

>>> rtl/core/tsb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tsb_ctrl.sv
// ----------------------------------------------------------------------------
// TDMA beacon builder controller
// Accepts requests and sequences the fetch and load of each beacon byte.
// ----------------------------------------------------------------------------
module tsb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    input  tsb_pkg::status_t status,
    output logic             s_tready,
    output tsb_pkg::cmd_t    cmd
);

    tsb_pkg::state_t state_reg;
    tsb_pkg::state_t state_next;
    logic            beacon_start;

    assign beacon_start = s_tvalid && (s_tuser == tsb_pkg::FUNC_TICK) && status.beacon_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsb_pkg::ST_IDLE:
            begin
                if (beacon_start)
                begin
                    state_next = tsb_pkg::ST_FETCH;
                end
            end
            tsb_pkg::ST_FETCH:
            begin
                state_next = tsb_pkg::ST_LOAD;
            end
            tsb_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.last_idx ? tsb_pkg::ST_IDLE : tsb_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = tsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = 1'b0;
        cmd.take        = 1'b0;
        cmd.start_frame = 1'b0;
        cmd.fetch       = 1'b0;
        cmd.load        = 1'b0;
        unique case (state_reg)
            tsb_pkg::ST_IDLE:
            begin
                s_tready        = 1'b1;
                cmd.take        = s_tvalid;
                cmd.start_frame = beacon_start;
            end
            tsb_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            tsb_pkg::ST_LOAD:
            begin
                cmd.load = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/tsb_datapath.sv
// ----------------------------------------------------------------------------
// TDMA beacon builder datapath
// Configuration, tick timing, slot table and the beacon output register.
// ----------------------------------------------------------------------------
module tsb_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             s_tuser,
    input  logic [7:0]       s_tdata,
    input  logic             m_tready,
    input  tsb_pkg::cmd_t    cmd,
    output tsb_pkg::status_t status,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic [15:0] period_reg;
    logic [15:0] guard_reg;
    logic [15:0] slot_len_reg;
    logic [5:0]  count_reg;

    logic [15:0] pcount_reg;
    logic [15:0] phase_reg;
    logic [5:0]  slot_reg;
    logic [7:0]  seq_reg;
    logic        first_reg;
    logic [tsb_pkg::MAX_SLOTS-1:0] valid_reg;

    logic [5:0]  idx_reg;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        ovalid_reg;

    logic [16:0] pcount_next;
    logic [16:0] phase_inc;
    logic [5:0]  used_slots;
    logic [5:0]  entry_idx;
    logic        tick_take;
    logic        pkt_write;
    logic        frame_done;
    logic [7:0]  ram_rdata;
    logic [7:0]  byte_next;

    assign used_slots  = (count_reg > 6'(tsb_pkg::MAX_SLOTS)) ?
                         6'(tsb_pkg::MAX_SLOTS) : count_reg;
    assign pcount_next = {1'b0, pcount_reg} + 17'd1;
    assign phase_inc   = {1'b0, phase_reg} + 17'd1;
    assign entry_idx   = idx_reg - 6'(tsb_pkg::HDR_LEN);
    assign tick_take   = cmd.take && (s_tuser == tsb_pkg::FUNC_TICK);
    assign pkt_write   = cmd.take && (s_tuser == tsb_pkg::FUNC_PACKET) && first_reg
                         && (pcount_reg >= guard_reg) && (slot_reg < used_slots);
    assign frame_done  = cmd.load && status.last_idx;

    assign status.beacon_hit = pcount_next >= {1'b0, period_reg};
    assign status.out_free   = !ovalid_reg || m_tready;
    assign status.last_idx   = ({1'b0, idx_reg} + 7'd1)
                               == (7'(tsb_pkg::HDR_LEN) + {1'b0, used_slots});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= tsb_pkg::PERIOD_RESET;
            guard_reg    <= tsb_pkg::GUARD_RESET;
            slot_len_reg <= tsb_pkg::SLOT_RESET;
            count_reg    <= tsb_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsb_pkg::CFG_PERIOD: period_reg   <= cfg_data;
                tsb_pkg::CFG_GUARD:  guard_reg    <= cfg_data;
                tsb_pkg::CFG_SLOT:   slot_len_reg <= cfg_data;
                tsb_pkg::CFG_COUNT:  count_reg    <= cfg_data[5:0];
                default:             count_reg    <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
            phase_reg  <= '0;
            slot_reg   <= '0;
            first_reg  <= 1'b0;
        end
        else if (tick_take)
        begin
            if (status.beacon_hit)
            begin
                pcount_reg <= '0;
                phase_reg  <= '0;
                slot_reg   <= '0;
                first_reg  <= 1'b1;
            end
            else
            begin
                pcount_reg <= pcount_next[15:0];
                if (pcount_next > {1'b0, guard_reg})
                begin
                    if (phase_inc >= {1'b0, slot_len_reg})
                    begin
                        phase_reg <= '0;
                        if (slot_reg != 6'd63)
                        begin
                            slot_reg <= slot_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_inc[15:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seq_reg   <= '0;
        end
        else if (frame_done)
        begin
            valid_reg <= '0;
            seq_reg   <= seq_reg + 8'd1;
        end
        else if (pkt_write)
        begin
            valid_reg[slot_reg[tsb_pkg::SLOT_AW-1:0]] <= 1'b1;
        end
    end

    tsb_ram #(
        .WIDTH(8),
        .DEPTH(tsb_pkg::MAX_SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (pkt_write),
        .waddr(slot_reg[tsb_pkg::SLOT_AW-1:0]),
        .wdata(s_tdata),
        .re   (cmd.fetch),
        .raddr(entry_idx[tsb_pkg::SLOT_AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        if (idx_reg < 6'(tsb_pkg::HDR_LEN - 1))
        begin
            byte_next = tsb_pkg::FRAME_HEAD[idx_reg[2:0]];
        end
        else if (idx_reg == 6'(tsb_pkg::HDR_LEN - 1))
        begin
            byte_next = seq_reg;
        end
        else if (valid_reg[entry_idx[tsb_pkg::SLOT_AW-1:0]])
        begin
            byte_next = ram_rdata;
        end
        else
        begin
            byte_next = tsb_pkg::FREE_ENTRY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_frame)
            begin
                idx_reg <= '0;
            end
            else if (cmd.load)
            begin
                idx_reg <= idx_reg + 6'd1;
            end
            if (cmd.load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            obyte_reg <= byte_next;
            olast_reg <= status.last_idx;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

endmodule

>>> rtl/core/tdma_slot_beacon_builder.sv
// ----------------------------------------------------------------------------
// TDMA slot recorder and beacon builder
// Records node ids per slot and streams a beacon frame each period.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                                 Content
// s_*       in         s_tvalid s_tready s_tdata s_tuser       tick or received packet
// m_*       out        m_tvalid m_tready m_tdata m_tlast       beacon frame bytes
// cfg_*     in         cfg_we cfg_index cfg_data               register writes
//
// A tick or packet request without a beacon leaves the controller idle.
// A tick that ends the period emits 9 to 41 bytes, each by a slot table
// read and then an output register load.
// Reset clears the slot table valid flags at once; there is no clearing pass.
// A stalled output holds the byte load; input is refused until the frame ends.
// ----------------------------------------------------------------------------
module tdma_slot_beacon_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] node_id
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] beacon_byte
    output logic        m_tlast
);

    tsb_pkg::cmd_t    cmd;
    tsb_pkg::status_t status;

    tsb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tuser (s_tuser),
        .status  (status),
        .s_tready(s_tready),
        .cmd     (cmd)
    );

    tsb_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> status.out_free)
        else $error("byte loaded while output register full");

    a_beacon_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser && status.beacon_hit) |=> !s_tready)
        else $error("input accepted after a beacon tick");

    a_last_byte_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.last_idx) |=> (m_tvalid && m_tlast))
        else $error("final frame byte not marked");

endmodule
